/* sv/jets_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package jets_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int FRAC_BITS      = 28;
   localparam int QUEUE_DEPTH    = 2;

   localparam int COORD_WIDTH    = 32;
   localparam int POS_WIDTH      = 12;
   localparam int COUNT_WIDTH    = 16;
   localparam int PAL_OUT_WIDTH  = 8;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_IDX_WIDTH  = CSR_ADDR_WIDTH - 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = 2 * POS_WIDTH;
   localparam int RSP_DATA_WIDTH = 2 * POS_WIDTH + COUNT_WIDTH + PAL_OUT_WIDTH;

   // register indexes, byte address is 4 * index
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_X_ORIGIN   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_Y_ORIGIN   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STEP_X     = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STEP_Y     = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_C_REAL     = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_C_IMAG     = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ITER_LIMIT = 3'd6;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x_origin;
      logic signed [COORD_WIDTH-1:0] y_origin;
      logic signed [COORD_WIDTH-1:0] step_x;
      logic signed [COORD_WIDTH-1:0] step_y;
      logic signed [COORD_WIDTH-1:0] c_real;
      logic signed [COORD_WIDTH-1:0] c_imag;
      logic [COUNT_WIDTH-1:0]        iteration_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      x_origin:        -32'sd536870912,
      y_origin:        -32'sd536870912,
      step_x:          32'sd0,
      step_y:          32'sd0,
      c_real:          -32'sd187904819,
      c_imag:          32'sd72517838,
      iteration_limit: 16'd256
   };

   typedef struct packed {
      logic [POS_WIDTH-1:0]          column;
      logic [POS_WIDTH-1:0]          row;
      logic signed [COORD_WIDTH-1:0] z_real;
      logic signed [COORD_WIDTH-1:0] z_imag;
   } point_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_MUL,
      B_STEP,
      B_DONE
   } back_state_type;

   localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
   localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

   function automatic logic signed [COORD_WIDTH-1:0] sat32(input logic signed [64:0] v);
      logic signed [COORD_WIDTH-1:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = $signed(v[COORD_WIDTH-1:0]);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/jets_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
module jets_csr (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_psel,
   input  wire logic                                    csr_penable,
   input  wire logic                                    csr_pwrite,
   input  wire logic [jets_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  wire logic [jets_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic      [jets_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                         csr_pready,
   output jets_pkg::cfg_type                            cfg
);

   jets_pkg::cfg_type cfg_ff;
   jets_pkg::cfg_type cfg_in;
   logic [jets_pkg::CSR_IDX_WIDTH-1:0] idx;
   logic wr;

   assign csr_pready = 1'b1;
   assign idx = csr_paddr[jets_pkg::CSR_ADDR_WIDTH-1:2];
   assign wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            jets_pkg::CSR_X_ORIGIN:   cfg_in.x_origin = $signed(csr_pwdata);
            jets_pkg::CSR_Y_ORIGIN:   cfg_in.y_origin = $signed(csr_pwdata);
            jets_pkg::CSR_STEP_X:     cfg_in.step_x   = $signed(csr_pwdata);
            jets_pkg::CSR_STEP_Y:     cfg_in.step_y   = $signed(csr_pwdata);
            jets_pkg::CSR_C_REAL:     cfg_in.c_real   = $signed(csr_pwdata);
            jets_pkg::CSR_C_IMAG:     cfg_in.c_imag   = $signed(csr_pwdata);
            jets_pkg::CSR_ITER_LIMIT: begin
               cfg_in.iteration_limit = csr_pwdata[jets_pkg::COUNT_WIDTH-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= jets_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         jets_pkg::CSR_X_ORIGIN:   csr_prdata = cfg_ff.x_origin;
         jets_pkg::CSR_Y_ORIGIN:   csr_prdata = cfg_ff.y_origin;
         jets_pkg::CSR_STEP_X:     csr_prdata = cfg_ff.step_x;
         jets_pkg::CSR_STEP_Y:     csr_prdata = cfg_ff.step_y;
         jets_pkg::CSR_C_REAL:     csr_prdata = cfg_ff.c_real;
         jets_pkg::CSR_C_IMAG:     csr_prdata = cfg_ff.c_imag;
         jets_pkg::CSR_ITER_LIMIT: begin
            csr_prdata = jets_pkg::CSR_DATA_WIDTH'(cfg_ff.iteration_limit);
         end
         default:                  csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

/* sv/jets_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module jets_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire jets_pkg::cfg_type                    cfg,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [jets_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                      push_valid,
   input  wire logic                                 push_ready,
   output jets_pkg::point_type                       push_data
);

   localparam int PROD_WIDTH = jets_pkg::COORD_WIDTH + jets_pkg::POS_WIDTH + 1;

   jets_pkg::front_state_type state_ff, state_in;
   logic [jets_pkg::POS_WIDTH-1:0] col_ff, col_in;
   logic [jets_pkg::POS_WIDTH-1:0] row_ff, row_in;
   logic signed [PROD_WIDTH-1:0]   prod_x_ff, prod_x_in;
   logic signed [PROD_WIDTH-1:0]   prod_y_ff, prod_y_in;
   logic signed [64:0]             sum_x, sum_y;
   logic                           accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jets_pkg::F_IDLE: if (accept) state_in = jets_pkg::F_MUL;
         jets_pkg::F_MUL:  state_in = jets_pkg::F_PUSH;
         jets_pkg::F_PUSH: if (push_ready) state_in = jets_pkg::F_IDLE;
         default:          state_in = jets_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == jets_pkg::F_IDLE);
      push_valid = (state_ff == jets_pkg::F_PUSH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jets_pkg::F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // index times step, then origin plus offset with saturation
   always_comb begin
      col_in    = accept ? req_tdata[jets_pkg::POS_WIDTH-1:0] : col_ff;
      row_in    = accept ? req_tdata[jets_pkg::REQ_DATA_WIDTH-1:jets_pkg::POS_WIDTH] : row_ff;
      prod_x_in = $signed({1'b0, col_ff}) * cfg.step_x;
      prod_y_in = $signed({1'b0, row_ff}) * cfg.step_y;
   end

   always_ff @(posedge clock) begin
      col_ff    <= col_in;
      row_ff    <= row_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
   end

   assign sum_x = 65'(cfg.x_origin) + 65'(prod_x_ff);
   assign sum_y = 65'(cfg.y_origin) + 65'(prod_y_ff);

   always_comb begin
      push_data.column = col_ff;
      push_data.row    = row_ff;
      push_data.z_real = jets_pkg::sat32(sum_x);
      push_data.z_imag = jets_pkg::sat32(sum_y);
   end

endmodule
`default_nettype wire

/* sv/jets_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
module jets_fifo #(
   parameter int DEPTH = jets_pkg::QUEUE_DEPTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   output logic               push_ready,
   input  wire jets_pkg::point_type push_data,
   input  wire logic          pop,
   output logic               pop_valid,
   output jets_pkg::point_type pop_data
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

   jets_pkg::point_type entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] fill_ff, fill_in;
   logic push;

   assign push_ready = (fill_ff != CNT_FULL);
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* sv/jets_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module jets_back #(
   parameter int FRAC_BITS       = jets_pkg::FRAC_BITS,
   parameter int PALETTE_ENTRIES = jets_pkg::PALETTE_ENTRIES
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire jets_pkg::cfg_type                    cfg,
   input  wire logic                                 pop_valid,
   input  wire jets_pkg::point_type                  pop_data,
   output logic                                      pop,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [jets_pkg::RSP_DATA_WIDTH-1:0]       rsp_tdata,
   output logic                                      rsp_tuser
);

   localparam int PAL_WIDTH = $clog2(PALETTE_ENTRIES);
   localparam logic [PAL_WIDTH-1:0] PAL_LAST = PAL_WIDTH'(PALETTE_ENTRIES - 1);
   localparam logic [63:0] ESC_BOUND = 64'd4 << (2 * FRAC_BITS);
   localparam int CW = jets_pkg::COORD_WIDTH;
   localparam int NW = jets_pkg::COUNT_WIDTH;
   localparam int PW = jets_pkg::POS_WIDTH;

   jets_pkg::back_state_type state_ff, state_in;
   logic signed [CW-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [63:0]   rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [NW-1:0]        count_ff, count_in;
   logic [PAL_WIDTH-1:0] pal_ff, pal_in;
   logic [PW-1:0]        col_ff, col_in, row_ff, row_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0]        rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic [NW-1:0]        rsp_count_ff, rsp_count_in;
   logic                 rsp_esc_ff, rsp_esc_in;
   logic [jets_pkg::PAL_OUT_WIDTH-1:0] rsp_pal_ff, rsp_pal_in;

   logic load_prod, update, emit, out_free, finish, escaped;
   logic [63:0] mag;
   logic signed [63:0] diff, diff_sh, ri_sh;
   logic signed [CW-1:0] nr, ni;
   logic [PAL_WIDTH+jets_pkg::PAL_OUT_WIDTH-1:0] pal_ext;

   // escape test on |z|^2 and the next z from the registered products
   assign mag     = $unsigned(rr_ff) + $unsigned(ii_ff);
   assign finish  = (mag >= ESC_BOUND) || (count_ff >= cfg.iteration_limit);
   assign diff    = rr_ff - ii_ff;
   assign diff_sh = diff >>> FRAC_BITS;
   assign ri_sh   = ri_ff >>> (FRAC_BITS - 1);
   assign nr      = jets_pkg::sat32(65'(diff_sh) + 65'(cfg.c_real));
   assign ni      = jets_pkg::sat32(65'(ri_sh) + 65'(cfg.c_imag));
   assign escaped = (count_ff < cfg.iteration_limit);
   assign pal_ext = {{jets_pkg::PAL_OUT_WIDTH{1'b0}}, pal_ff};
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jets_pkg::B_IDLE: if (pop_valid) state_in = jets_pkg::B_MUL;
         jets_pkg::B_MUL:  state_in = jets_pkg::B_STEP;
         jets_pkg::B_STEP: state_in = finish ? jets_pkg::B_DONE : jets_pkg::B_MUL;
         jets_pkg::B_DONE: if (out_free) state_in = jets_pkg::B_IDLE;
         default:          state_in = jets_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop       = (state_ff == jets_pkg::B_IDLE) && pop_valid;
      load_prod = (state_ff == jets_pkg::B_MUL);
      update    = (state_ff == jets_pkg::B_STEP) && !finish;
      emit      = (state_ff == jets_pkg::B_DONE) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jets_pkg::B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      count_in = count_ff;
      pal_in   = pal_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      rr_in    = rr_ff;
      ii_in    = ii_ff;
      ri_in    = ri_ff;
      if (pop) begin
         zr_in    = pop_data.z_real;
         zi_in    = pop_data.z_imag;
         col_in   = pop_data.column;
         row_in   = pop_data.row;
         count_in = NW'(1);
         pal_in   = PAL_WIDTH'(1);
      end
      if (load_prod) begin
         rr_in = zr_ff * zr_ff;
         ii_in = zi_ff * zi_ff;
         ri_in = zr_ff * zi_ff;
      end
      if (update) begin
         zr_in    = nr;
         zi_in    = ni;
         count_in = count_ff + 1'b1;
         // count modulo palette size tracked alongside the count
         pal_in   = (pal_ff == PAL_LAST) ? '0 : pal_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      count_ff <= count_in;
      pal_ff   <= pal_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      rr_ff    <= rr_in;
      ii_ff    <= ii_in;
      ri_ff    <= ri_in;
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_count_in = rsp_count_ff;
      rsp_esc_in   = rsp_esc_ff;
      rsp_pal_in   = rsp_pal_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_col_in   = col_ff;
         rsp_row_in   = row_ff;
         rsp_count_in = count_ff;
         rsp_esc_in   = escaped;
         rsp_pal_in   = escaped ? pal_ext[jets_pkg::PAL_OUT_WIDTH-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_count_ff <= rsp_count_in;
      rsp_esc_ff   <= rsp_esc_in;
      rsp_pal_ff   <= rsp_pal_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_pal_ff, rsp_count_ff, rsp_row_ff, rsp_col_ff};
   assign rsp_tuser  = rsp_esc_ff;

endmodule
`default_nettype wire

/* sv/julia_escape_time_pixel_top.sv */
// a req beat passes F_MUL, F_PUSH, the queue, B_MUL/B_STEP per iteration, B_DONE, output register
// the back end takes a new pixel from the queue only once the last one has left B_DONE;
//   each iteration is multiply (B_MUL), then update (B_STEP) on the shared product registers
// front end takes a new pixel once the last is pushed; a push waits for room in the 2-entry queue
// reset is synchronous and active high: state and config registers return to their reset values,
//   queue and output register empty
`timescale 1ns / 1ps
`default_nettype none
module julia_escape_time_pixel_top #(
   parameter int PALETTE_ENTRIES = jets_pkg::PALETTE_ENTRIES,
   parameter int FRAC_BITS       = jets_pkg::FRAC_BITS,
   parameter int QUEUE_DEPTH     = jets_pkg::QUEUE_DEPTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // column [11:0], row [23:12]
   input  wire logic [jets_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // out_column [11:0], out_row [23:12], iteration_count [39:24], palette_index [47:40]
   output logic [jets_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   // escaped [0]
   output logic                                     rsp_tuser,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [jets_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [jets_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [jets_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                     csr_pready
);

   jets_pkg::cfg_type   cfg;
   jets_pkg::point_type push_data, pop_data;
   logic push_valid, push_ready, pop, pop_valid;

   jets_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   jets_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   jets_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   jets_back #(
      .FRAC_BITS       (FRAC_BITS),
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

/* sv/jets_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module jets_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [jets_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input wire logic                                rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // front end is busy for the cycle after it takes a pixel
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken on back-to-back cycles");

   a_pal_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[47:40] == 8'd0)
      else $error("palette index set for a point inside the set");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:24] != 16'd0)
      else $error("iteration count of zero");

endmodule

bind julia_escape_time_pixel_top jets_checker u_checker (.*);
`default_nettype wire
